// File: hdl/crcp_pkg.sv
// ----------------------------------------------------------------------------
// Code region cycle profiler package
// Shared constants, command codes and types of the profiler.
// ----------------------------------------------------------------------------
package crcp_pkg;

	localparam int NUM_REGIONS_DEF = 4;
	localparam int STACK_DEPTH_DEF = 1024;
	localparam int CNT_W = 64;

	localparam logic [1:0] CMD_STEP_START = 2'd0;
	localparam logic [1:0] CMD_STEP_END   = 2'd1;
	localparam logic [1:0] CMD_CLEAR      = 2'd2;
	localparam logic [1:0] CMD_READ       = 2'd3;

	localparam logic [2:0] CFG_ENABLE = 3'd0;
	localparam logic [2:0] CFG_COUNT  = 3'd1;
	localparam logic [2:0] CFG_BOUNDS = 3'd2;
	localparam int NUM_BOUND_REGS = 4;

	typedef struct packed {
		logic go;
		logic wb;
		logic clr;
	} bank_ctl_t;

	typedef struct packed {
		logic [CNT_W-1:0] hits;
		logic [CNT_W-1:0] cycles;
		logic [CNT_W-1:0] peak;
		logic [CNT_W-1:0] waits;
		logic [CNT_W-1:0] idle;
	} stats_t;

	typedef struct packed {
		logic [CNT_W-1:0] cycles;
		logic [CNT_W-1:0] waits;
		logic [CNT_W-1:0] idle;
	} totals_t;

endpackage

// File: hdl/crcp_bank.sv
// ----------------------------------------------------------------------------
// Region bank
// Start stack memory, stack level and statistics of one region.
// ----------------------------------------------------------------------------
module crcp_bank import crcp_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  bank_ctl_t   ctl,
	input  logic        active,
	input  logic [15:0] pc,
	input  logic [31:0] bounds,
	input  totals_t     totals,
	output stats_t      stats
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int LW = $clog2(STACK_DEPTH + 1);

	totals_t         mem [STACK_DEPTH];
	totals_t         rd_s1;
	logic            pop_s1;
	logic            push_s1;
	logic [LW-1:0]   level_q;
	stats_t          stats_q;
	logic [LW-1:0]   level_dec;
	logic [LW-1:0]   level_mid;
	logic [CNT_W-1:0] span;
	logic            push_ok;

	assign level_dec = level_q - LW'(1);
	assign level_mid = pop_s1 ? level_dec : level_q;
	assign span      = totals.cycles - rd_s1.cycles;
	assign push_ok   = push_s1 && (32'(level_mid) < STACK_DEPTH);
	assign stats     = stats_q;

	always_ff @(posedge clk) begin
		if (ctl.go) begin
			rd_s1 <= mem[level_dec[AW-1:0]];
		end
		if (ctl.wb && push_ok) begin
			mem[level_mid[AW-1:0]] <= totals;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_s1  <= 1'b0;
			push_s1 <= 1'b0;
			level_q <= '0;
			stats_q <= '0;
		end else if (ctl.clr) begin
			level_q <= '0;
			stats_q <= '0;
		end else begin
			if (ctl.go) begin
				pop_s1  <= active && (pc == bounds[31:16]) && (level_q != '0);
				push_s1 <= active && (pc == bounds[15:0]);
			end
			if (ctl.wb) begin
				level_q <= push_ok ? level_mid + LW'(1) : level_mid;
				if (pop_s1) begin
					stats_q.hits   <= stats_q.hits + CNT_W'(1);
					stats_q.cycles <= stats_q.cycles + span;
					if (span > stats_q.peak) begin
						stats_q.peak <= span;
					end
					stats_q.waits  <= stats_q.waits + (totals.waits - rd_s1.waits);
					stats_q.idle   <= stats_q.idle + (totals.idle - rd_s1.idle);
				end
			end
		end
	end

endmodule

// File: hdl/code_region_cycle_profiler_core.sv
// ----------------------------------------------------------------------------
// Code region cycle profiler core
// A beat other than a checked step start goes straight to the output state,
// from which the result strobe is registered. A step start with profiling
// enabled and is_instruction set first reads the region stack tops and
// then writes them back, so busy is high for one cycle before the output
// state. The receiver cannot stall.
// Reset clears totals, statistics and stack levels; stack memories are not.
// ----------------------------------------------------------------------------
module code_region_cycle_profiler_core import crcp_pkg::*; #(
	parameter int NUM_REGIONS = NUM_REGIONS_DEF,
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic [1:0]  cmd,
	input  logic [15:0] pc,
	input  logic        is_instruction,
	input  logic [31:0] elapsed,
	input  logic [31:0] waits,
	input  logic [31:0] idle,
	input  logic [1:0]  region_index,
	output logic [63:0] region_hits,
	output logic [63:0] region_cycles,
	output logic [63:0] region_max_cycles,
	output logic [63:0] region_wait_cycles,
	output logic [63:0] region_idle_cycles,
	output logic [63:0] total_cycles
);

	localparam int RW = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;

	typedef enum logic [1:0] {ST_IDLE, ST_WB, ST_OUT} state_t;

	state_t      state_q;
	logic        enable_q;
	logic [2:0]  count_q;
	logic [31:0] bounds_q [NUM_REGIONS];
	totals_t     totals_q;
	logic [1:0]  ridx_q;
	logic        done_q;
	stats_t      out_q;
	stats_t      stats_a [NUM_REGIONS];
	bank_ctl_t   ctl;
	logic        accept;
	logic        go;

	assign busy   = (state_q == ST_WB);
	assign accept = start && !busy;
	assign go     = accept && (cmd == CMD_STEP_START) && enable_q && is_instruction;
	assign ctl.go  = go;
	assign ctl.wb  = (state_q == ST_WB);
	assign ctl.clr = accept && (cmd == CMD_CLEAR);

	genvar r;
	generate
		for (r = 0; r < NUM_REGIONS; r++) begin : g_bank
			crcp_bank #(.STACK_DEPTH(STACK_DEPTH)) u_bank (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.active (32'(count_q) > r),
				.pc     (pc),
				.bounds (bounds_q[r]),
				.totals (totals_q),
				.stats  (stats_a[r])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			count_q  <= '0;
			for (int i = 0; i < NUM_REGIONS; i++) begin
				bounds_q[i] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == CFG_ENABLE) begin
				enable_q <= cfg_wdata[0];
			end else if (cfg_index == CFG_COUNT) begin
				count_q <= cfg_wdata[2:0];
			end else begin
				for (int i = 0; i < NUM_REGIONS; i++) begin
					if (i < NUM_BOUND_REGS && 32'(cfg_index) == 32'(CFG_BOUNDS) + i) begin
						bounds_q[i] <= cfg_wdata;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			done_q   <= 1'b0;
			totals_q <= '0;
			ridx_q   <= '0;
			out_q    <= '0;
		end else begin
			done_q <= (state_q == ST_OUT);
			if (state_q == ST_OUT) begin
				if (32'(ridx_q) < NUM_REGIONS) begin
					out_q <= stats_a[RW'(ridx_q)];
				end else begin
					out_q <= '0;
				end
			end
			if (accept) begin
				ridx_q  <= region_index;
				state_q <= go ? ST_WB : ST_OUT;
				if (cmd == CMD_STEP_END) begin
					totals_q.cycles <= totals_q.cycles + CNT_W'(elapsed);
					totals_q.waits  <= totals_q.waits + CNT_W'(waits);
					totals_q.idle   <= totals_q.idle + CNT_W'(idle);
				end else if (cmd == CMD_CLEAR) begin
					totals_q <= '0;
				end
			end else if (state_q == ST_WB) begin
				state_q <= ST_OUT;
			end else begin
				state_q <= ST_IDLE;
			end
		end
	end

	logic [63:0] total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (state_q == ST_OUT) begin
			total_q <= totals_q.cycles;
		end
	end

	assign done               = done_q;
	assign region_hits        = out_q.hits;
	assign region_cycles      = out_q.cycles;
	assign region_max_cycles  = out_q.peak;
	assign region_wait_cycles = out_q.waits;
	assign region_idle_cycles = out_q.idle;
	assign total_cycles       = total_q;

endmodule

// File: bench/crcp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Code region cycle profiler checker
// Watches the configuration port, the command beats and the result strobe,
// keeps its own copy of the profiler state, and compares every result beat
// field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module crcp_checker import crcp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        start,
	input  logic        busy,
	input  logic        done,
	input  logic [1:0]  cmd,
	input  logic [15:0] pc,
	input  logic        is_instruction,
	input  logic [31:0] elapsed,
	input  logic [31:0] waits,
	input  logic [31:0] idle,
	input  logic [1:0]  region_index,
	input  logic [63:0] region_hits,
	input  logic [63:0] region_cycles,
	input  logic [63:0] region_max_cycles,
	input  logic [63:0] region_wait_cycles,
	input  logic [63:0] region_idle_cycles,
	input  logic [63:0] total_cycles,
	output int          fail_count,
	output int          pending
);

	localparam int NR = NUM_REGIONS_DEF;
	localparam int SD = STACK_DEPTH_DEF;

	typedef struct packed {
		stats_t     st;
		logic [63:0] total;
	} profile_beat_t;

	logic        en_q;
	logic [2:0]  count_q;
	logic [31:0] bounds_q [NR];
	totals_t     run_q;
	totals_t     mark_q [NR][SD];
	int          level_q [NR];
	stats_t      stats_q [NR];
	profile_beat_t expected_beats [$];

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("result %s differs: got %h, want %h", what, got, want);
		fail_count++;
	endtask

	task automatic apply_step_start(input logic [15:0] addr);
		int used;
		logic [63:0] span;
		used = (count_q > NR) ? NR : count_q;
		for (int r = 0; r < used; r++) begin
			if (addr == bounds_q[r][31:16] && level_q[r] > 0) begin
				level_q[r]--;
				span = run_q.cycles - mark_q[r][level_q[r]].cycles;
				stats_q[r].hits += 1;
				stats_q[r].cycles += span;
				if (span > stats_q[r].peak) stats_q[r].peak = span;
				stats_q[r].waits += run_q.waits - mark_q[r][level_q[r]].waits;
				stats_q[r].idle += run_q.idle - mark_q[r][level_q[r]].idle;
			end
			if (addr == bounds_q[r][15:0] && level_q[r] < SD) begin
				mark_q[r][level_q[r]] = run_q;
				level_q[r]++;
			end
		end
	endtask

	task automatic clear_profile();
		run_q = '0;
		for (int r = 0; r < NR; r++) begin
			level_q[r] = 0;
			stats_q[r] = '0;
		end
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		en_q = 0;
		count_q = 0;
		for (int r = 0; r < NR; r++) bounds_q[r] = '0;
		clear_profile();
	end

	always @(posedge clk) begin
		profile_beat_t got, want;
		if (arst_n) begin
			if (done) begin
				got.st = {region_hits, region_cycles, region_max_cycles,
					region_wait_cycles, region_idle_cycles};
				got.total = total_cycles;
				if (expected_beats.size() == 0) begin
					$display("result beat with nothing expected");
					fail_count++;
				end else begin
					want = expected_beats[0];
					expected_beats.delete(0);
					if (got.st.hits !== want.st.hits) report("hits", got.st.hits, want.st.hits);
					if (got.st.cycles !== want.st.cycles)
						report("cycles", got.st.cycles, want.st.cycles);
					if (got.st.peak !== want.st.peak) report("peak", got.st.peak, want.st.peak);
					if (got.st.waits !== want.st.waits)
						report("waits", got.st.waits, want.st.waits);
					if (got.st.idle !== want.st.idle) report("idle", got.st.idle, want.st.idle);
					if (got.total !== want.total) report("total", got.total, want.total);
				end
			end
			if (cfg_we) begin
				if (cfg_index == CFG_ENABLE) en_q = cfg_wdata[0];
				else if (cfg_index == CFG_COUNT) count_q = cfg_wdata[2:0];
				else if (cfg_index >= CFG_BOUNDS && cfg_index < CFG_BOUNDS + NUM_BOUND_REGS)
					bounds_q[cfg_index - CFG_BOUNDS] = cfg_wdata;
			end
			if (start && !busy) begin
				case (cmd)
					CMD_STEP_START: begin
						if (en_q && is_instruction) apply_step_start(pc);
					end
					CMD_STEP_END: begin
						run_q.cycles += elapsed;
						run_q.waits += waits;
						run_q.idle += idle;
					end
					CMD_CLEAR: begin
						clear_profile();
					end
					default: ;
				endcase
				want.st = (region_index < NR) ? stats_q[region_index] : '0;
				want.total = run_q.cycles;
				expected_beats.insert(expected_beats.size(), want);
			end
			pending = expected_beats.size();
		end
	end

endmodule

// File: bench/tb_code_region_cycle_profiler_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Code region cycle profiler testbench
// Drives directed and random command beats with random gaps through several
// register settings; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_code_region_cycle_profiler_core;
	import crcp_pkg::*;

	logic        clk, arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_wdata;
	logic        start, busy, done;
	logic [1:0]  cmd;
	logic [15:0] pc;
	logic        is_instruction;
	logic [31:0] elapsed, waits, idle;
	logic [1:0]  region_index;
	logic [63:0] region_hits, region_cycles, region_max_cycles;
	logic [63:0] region_wait_cycles, region_idle_cycles, total_cycles;
	int          fail_count, pending;
	int          cycle_count;
	bit          gaps_on;
	logic [15:0] addr_pool [8];

	code_region_cycle_profiler_core u_top (.*);
	crcp_checker u_chk (.*);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 400000) begin
			$display("code_region_cycle_profiler_core: mismatch");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] index, input logic [31:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_beat(input logic [1:0] c, input logic [15:0] a, input logic ins,
		input logic [31:0] e, input logic [31:0] w, input logic [31:0] d, input logic [1:0] ri);
		if (gaps_on) begin
			while ($urandom_range(99) < 8) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start <= 1'b1;
		cmd <= c;
		pc <= a;
		is_instruction <= ins;
		elapsed <= e;
		waits <= w;
		idle <= d;
		region_index <= ri;
		do begin
			@(posedge clk);
		end while (busy);
	endtask

	task automatic random_phase(input int n);
		logic [1:0] c;
		for (int i = 0; i < n; i++) begin
			gaps_on = !(i > n / 3 && i < n / 2);
			c = $urandom_range(3);
			if ($urandom_range(9) < 4) c = CMD_STEP_START;
			send_beat(c,
				($urandom_range(9) < 8) ? addr_pool[$urandom_range(7)] : 16'($urandom),
				$urandom_range(9) != 0 || c != CMD_STEP_START,
				($urandom_range(9) < 2) ? 32'hFFFF_FFFF : $urandom,
				$urandom, $urandom,
				($urandom_range(19) == 0) ? 2'($urandom) : 2'($urandom_range(3)));
			if (i == n / 4) wait_drained();
		end
		wait_drained();
	endtask

	task automatic setup(input logic en, input logic [2:0] cnt);
		for (int r = 0; r < 4; r++) begin
			addr_pool[2 * r] = 16'($urandom);
			addr_pool[2 * r + 1] = ($urandom_range(5) == 0) ? addr_pool[2 * r] : 16'($urandom);
			write_reg(CFG_BOUNDS + 3'(r), {addr_pool[2 * r + 1], addr_pool[2 * r]});
		end
		write_reg(CFG_ENABLE, {31'($urandom), en});
		write_reg(CFG_COUNT, {29'($urandom), cnt});
	endtask

	initial begin
		cycle_count = 0;
		gaps_on = 1;
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
		start = 1'b0; cmd = CMD_READ; pc = '0; is_instruction = 1'b0;
		elapsed = '0; waits = '0; idle = '0; region_index = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: nesting, begin equal to end, wrap, clear, reads.
		write_reg(CFG_BOUNDS, {16'h0020, 16'h0010});
		write_reg(CFG_BOUNDS + 3'd1, {16'hFFFF, 16'hFFFF});
		write_reg(CFG_BOUNDS + 3'd2, {16'h0000, 16'h0000});
		write_reg(CFG_BOUNDS + 3'd3, {16'h0020, 16'h0030});
		write_reg(CFG_ENABLE, 32'd1);
		write_reg(CFG_COUNT, 32'd7);
		send_beat(CMD_STEP_START, 16'h0010, 1, 0, 0, 0, 0);
		send_beat(CMD_STEP_END, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		send_beat(CMD_STEP_START, 16'h0010, 1, 0, 0, 0, 0);
		send_beat(CMD_STEP_END, 0, 0, 32'd5, 32'd2, 32'd1, 0);
		send_beat(CMD_STEP_START, 16'h0020, 1, 0, 0, 0, 0);
		send_beat(CMD_STEP_START, 16'h0020, 1, 0, 0, 0, 3);
		send_beat(CMD_STEP_START, 16'hFFFF, 1, 0, 0, 0, 1);
		send_beat(CMD_STEP_END, 0, 1, 32'd7, 32'd0, 32'd3, 1);
		send_beat(CMD_STEP_START, 16'hFFFF, 1, 0, 0, 0, 1);
		send_beat(CMD_STEP_START, 16'hFFFF, 0, 0, 0, 0, 1);
		send_beat(CMD_STEP_START, 16'h0000, 1, 0, 0, 0, 2);
		send_beat(CMD_READ, 16'hFFFF, 1, 0, 0, 0, 0);
		send_beat(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
		send_beat(CMD_READ, 0, 0, 0, 0, 0, 1);
		wait_drained();

		setup(1, 4);
		random_phase(250);
		setup(1, 1);
		random_phase(150);
		setup(0, 4);
		random_phase(60);
		setup(1, 0);
		random_phase(60);
		setup(1, 3'($urandom_range(5, 7)));
		random_phase(230);

		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("code_region_cycle_profiler_core: match");
		end else begin
			$display("code_region_cycle_profiler_core: mismatch");
		end
		$finish;
	end

endmodule
